[hdl/rtc_pkg.sv]
// Shared types, constants and helper functions of the binary RTC register device.
// No dependencies; rtc_ctrl, the top level and the checker import this package.
package rtc_pkg;

  // Register file geometry and read burst length
  localparam int REG_FILE_DEPTH = 16;
  localparam int READ_BURST_LEN = 8;
  localparam int AW = $clog2(REG_FILE_DEPTH);
  localparam int BW = $clog2(READ_BURST_LEN);

  // Register indexes of the time and calendar counters
  localparam logic [AW-1:0] IX_SEC   = AW'(0);
  localparam logic [AW-1:0] IX_MIN   = AW'(1);
  localparam logic [AW-1:0] IX_HOUR  = AW'(2);
  localparam logic [AW-1:0] IX_DAY   = AW'(3);
  localparam logic [AW-1:0] IX_DATE  = AW'(4);
  localparam logic [AW-1:0] IX_MONTH = AW'(5);
  localparam logic [AW-1:0] IX_YEAR  = AW'(6);

  // Counter limits
  localparam logic [7:0] SEC_LIMIT  = 8'd60;
  localparam logic [7:0] MIN_LIMIT  = 8'd60;
  localparam logic [7:0] HOUR_LIMIT = 8'd24;
  localparam logic [7:0] DAY_LAST   = 8'd7;
  localparam logic [7:0] MONTH_LAST = 8'd12;

  // Operation codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_READ   = 2'd1,
    OP_SETPTR = 2'd2,
    OP_WRITE  = 2'd3
  } op_e;

  // Register file access request from the sequencer
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
  } ram_req_t;

  // Tag that travels alongside a burst read, aligned with the RAM latency
  typedef struct packed {
    logic       vld;
    logic [2:0] idx;
    logic       last;
    logic       oob;
  } burst_tag_t;

  // Reset contents of the register file
  function automatic logic [7:0] init_val(logic [AW-1:0] a);
    logic [7:0] v;
    case (a)
      IX_SEC:   v = 8'd1;
      IX_DAY:   v = 8'd5;
      IX_DATE:  v = 8'd1;
      IX_MONTH: v = 8'd1;
      IX_YEAR:  v = 8'd70;
      default:  v = 8'd0;
    endcase
    return v;
  endfunction

  // Days in a month, no leap years; bad months count 31
  function automatic logic [7:0] month_days(logic [7:0] m);
    logic [7:0] d;
    case (m)
      8'd2:    d = 8'd28;
      8'd4:    d = 8'd30;
      8'd6:    d = 8'd30;
      8'd9:    d = 8'd30;
      8'd11:   d = 8'd30;
      default: d = 8'd31;
    endcase
    return d;
  endfunction

  // Wrap limit of seconds, minutes and hours
  function automatic logic [7:0] count_limit(logic [AW-1:0] ix);
    logic [7:0] l;
    case (ix)
      IX_SEC:  l = SEC_LIMIT;
      IX_MIN:  l = MIN_LIMIT;
      default: l = HOUR_LIMIT;
    endcase
    return l;
  endfunction

endpackage

[hdl/rtc_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module rtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/rtc_ctrl.sv]
// Sequencer of the RTC register device: init sweep, tick read-modify-write,
// read burst address issue, pointer and host writes. Depends on rtc_pkg.
module rtc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rtc_pkg::op_e        op_i,
  input  logic [7:0]          bus_data_i,
  output rtc_pkg::ram_req_t   ram_req_o,
  input  logic [7:0]          ram_rdata_i,
  output rtc_pkg::burst_tag_t burst_tag_o
);
  import rtc_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RD    = 6'b000100,
    ST_UPD   = 6'b001000,
    ST_MON   = 6'b010000,
    ST_BURST = 6'b100000
  } state_e;

  localparam logic [AW-1:0] InitLast  = AW'(REG_FILE_DEPTH - 1);
  localparam logic [BW-1:0] BurstLast = BW'(READ_BURST_LEN - 1);
  localparam logic [4:0]    Depth5    = 5'(REG_FILE_DEPTH);

  state_e     state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] fidx_q, fidx_d;
  logic [7:0]    month_q, month_d;
  logic [BW-1:0] bidx_q, bidx_d;
  logic [3:0]    ptr_q, ptr_d;
  burst_tag_t    tag_q, tag_d;
  ram_req_t      req;

  logic [7:0] inc;
  logic [4:0] ptr_inc;
  logic [3:0] ptr_next;
  logic       ptr_ok;
  logic [4:0] bidx_w;
  logic       boob;

  // Helpers: incremented byte, pointer advance, burst range check
  assign inc      = ram_rdata_i + 8'd1;
  assign ptr_ok   = {1'b0, ptr_q} < Depth5;
  assign ptr_inc  = {1'b0, ptr_q} + 5'd1;
  assign ptr_next = (ptr_inc >= Depth5 || ptr_inc > 5'd15) ? 4'd0 : ptr_inc[3:0];
  assign bidx_w   = 5'(bidx_q);
  assign boob     = bidx_w >= Depth5;

  // Next-state and RAM request logic
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fidx_d  = fidx_q;
    month_d = month_q;
    bidx_d  = bidx_q;
    ptr_d   = ptr_q;
    tag_d   = '0;
    req     = '0;
    case (state_q)
      ST_INIT: begin
        req.we    = 1'b1;
        req.waddr = cnt_q;
        req.wdata = init_val(cnt_q);
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == InitLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (op_i)
            OP_TICK: begin
              fidx_d  = IX_SEC;
              state_d = ST_RD;
            end
            OP_READ: begin
              bidx_d  = '0;
              state_d = ST_BURST;
            end
            OP_SETPTR: begin
              ptr_d = bus_data_i[3:0];
            end
            OP_WRITE: begin
              req.we    = ptr_ok;
              req.waddr = ptr_q[AW-1:0];
              req.wdata = bus_data_i;
              ptr_d     = ptr_next;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        req.raddr = fidx_q;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        req.waddr = fidx_q;
        case (fidx_q)
          IX_SEC, IX_MIN, IX_HOUR: begin
            req.we = 1'b1;
            if (inc < count_limit(fidx_q)) begin
              req.wdata = inc;
              state_d   = ST_IDLE;
            end else begin
              req.wdata = 8'd0;
              fidx_d    = fidx_q + AW'(1);
              state_d   = ST_RD;
            end
          end
          IX_DAY: begin
            req.we    = 1'b1;
            req.wdata = (ram_rdata_i >= DAY_LAST) ? 8'd1 : inc;
            fidx_d    = IX_MONTH;
            state_d   = ST_RD;
          end
          IX_MONTH: begin
            // month is needed before the date can roll
            month_d = ram_rdata_i;
            fidx_d  = IX_DATE;
            state_d = ST_RD;
          end
          IX_DATE: begin
            req.we = 1'b1;
            if (ram_rdata_i >= month_days(month_q)) begin
              req.wdata = 8'd1;
              state_d   = ST_MON;
            end else begin
              req.wdata = inc;
              state_d   = ST_IDLE;
            end
          end
          IX_YEAR: begin
            req.we    = 1'b1;
            req.wdata = inc;
            state_d   = ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_MON: begin
        req.we    = 1'b1;
        req.waddr = IX_MONTH;
        if (month_q >= MONTH_LAST) begin
          req.wdata = 8'd1;
          fidx_d    = IX_YEAR;
          state_d   = ST_RD;
        end else begin
          req.wdata = month_q + 8'd1;
          state_d   = ST_IDLE;
        end
      end
      ST_BURST: begin
        // one read issued per cycle, tag follows the RAM latency
        req.raddr = boob ? '0 : bidx_w[AW-1:0];
        tag_d.vld  = 1'b1;
        tag_d.idx  = bidx_w[2:0];
        tag_d.last = bidx_q == BurstLast;
        tag_d.oob  = boob;
        bidx_d     = bidx_q + BW'(1);
        if (bidx_q == BurstLast) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      ptr_q   <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      tag_q   <= tag_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    fidx_q  <= fidx_d;
    month_q <= month_d;
    bidx_q  <= bidx_d;
  end

  assign busy        = state_q != ST_IDLE;
  assign ram_req_o   = req;
  assign burst_tag_o = tag_q;

endmodule

[hdl/rtc_calendar_register_device_top.sv]
// Top level of the binary RTC register device: sequencer, register file RAM
// and result formatting. Depends on rtc_pkg, rtc_ctrl and rtc_ram.

// After reset the block loads every register file entry with its reset
// contents (busy high, no word accepted). A word is accepted when start
// is high and busy is low. Set-pointer and write words leave busy low, so the
// next word can follow at once. A second tick walks the counters with one
// RAM read and one write-back each, so busy stays high until the last counter
// that moves is written back, longest on a year rollover. A read burst keeps
// busy high while it issues one RAM read per cycle, and its 8 words appear on
// consecutive cycles after the burst state and the registered RAM read, each for
// a single cycle with strobe_o high; the receiver cannot stall them.
module rtc_calendar_register_device_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op_i,
  input  logic [7:0] bus_data_i,
  output logic       strobe_o,
  output logic [7:0] read_data_o,
  output logic [2:0] read_index_o,
  output logic       burst_last_o
);
  import rtc_pkg::*;

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  burst_tag_t tag;

  // Sequencer
  rtc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_e'(op_i)),
    .bus_data_i  (bus_data_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .burst_tag_o (tag)
  );

  // Register file
  rtc_ram #(
    .WIDTH (8),
    .DEPTH (REG_FILE_DEPTH)
  ) u_regfile (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Result word: bytes past the file read as zero
  assign strobe_o     = tag.vld;
  assign read_data_o  = tag.oob ? 8'd0 : ram_rdata;
  assign read_index_o = tag.idx;
  assign burst_last_o = tag.vld & tag.last;

endmodule

[hdl/rtc_checker.sv]
// Port-level checker of the RTC register device, bound to the top level.
// Depends on rtc_pkg and rtc_calendar_register_device_top.
module rtc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] op_i,
  input logic [7:0] bus_data_i,
  input logic       strobe_o,
  input logic [7:0] read_data_o,
  input logic [2:0] read_index_o,
  input logic       burst_last_o
);
  import rtc_pkg::*;

  localparam logic [2:0] LastIdx = 3'(READ_BURST_LEN - 1);

  // Burst words come back to back with rising index
  a_burst_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !burst_last_o |=> strobe_o && read_index_o == $past(read_index_o) + 3'd1)
    else $error("burst word missing or index out of order");

  // The last flag sits on the final index
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_last_o |-> strobe_o && read_index_o == LastIdx)
    else $error("burst_last on wrong index");

  // No new word is taken while a burst is still mid-way
  a_busy_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !burst_last_o |-> busy)
    else $error("not busy during burst");

  // A non-read word never produces a result in the next cycle
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && op_i != OP_READ |=> !strobe_o)
    else $error("unexpected result word");

  // A read word opens its burst at index zero, after the burst issue state and the registered RAM read
  a_read_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && op_i == OP_READ |-> ##2 strobe_o && read_index_o == 3'd0)
    else $error("burst did not start at index zero");

endmodule

bind rtc_calendar_register_device_top rtc_checker u_rtc_checker (.*);
